FILE: hw/rtl/fph_pkg.sv
// Shared constants, types and register codes for the fragment Phong shader.
`default_nettype none

package fph_pkg;

    // Color fixed point: Q3.12
    localparam int CFRAC    = 12;
    localparam int ONE_VAL  = 1 << CFRAC;
    localparam int AMB_K    = (3 * ONE_VAL + 5) / 10;

    // Vector normalizer geometry
    localparam int NIN_W    = 34;                 // signed input component
    localparam int MS_W     = 20;                 // scaled magnitude
    localparam int ROOT_W   = MS_W + 1;           // length bits
    localparam int LEN2_W   = 2 * ROOT_W;         // sum of squares
    localparam int QB       = CFRAC + 1;          // quotient bits
    localparam int NOUT_W   = CFRAC + 2;          // signed unit component
    localparam int NORM_LAT = 5 + ROOT_W + QB + 1;

    typedef logic signed [NIN_W-1:0]  nin_t;
    typedef logic signed [NOUT_W-1:0] nout_t;

    typedef enum logic [1:0] {
        MODE_UNLIT   = 2'd0,
        MODE_DIFFUSE = 2'd1,
        MODE_PHONG   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_TEX  = 3'd1,
        REG_BASE = 3'd2,
        REG_LDIR = 3'd3,
        REG_LCOL = 3'd4,
        REG_CAMX = 3'd5,
        REG_CAMY = 3'd6,
        REG_CAMZ = 3'd7
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fph_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
`default_nettype none

module fph_norm (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire fph_pkg::nin_t  vec_i [3],
    output fph_pkg::nout_t      vec_o [3]
);

    localparam int NW   = fph_pkg::NIN_W;
    localparam int MW   = fph_pkg::MS_W;
    localparam int RW   = fph_pkg::ROOT_W;
    localparam int L2W  = fph_pkg::LEN2_W;
    localparam int TW   = L2W + 1;
    localparam int QB   = fph_pkg::QB;
    localparam int DR   = MW + fph_pkg::CFRAC;
    localparam int DW   = DR + 2;
    localparam int LW   = $clog2(NW);
    localparam logic [LW-1:0] TOP = LW'(MW - 1);

    // Stage 1: magnitudes, signs, largest magnitude
    logic [2:0][NW-1:0] mag1_reg, mag1_next;
    logic [2:0]         neg1_reg, neg1_next;
    logic [NW-1:0]      mx1_reg, mx1_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg1_next[i] = vec_i[i][NW-1];
            mag1_next[i] = neg1_next[i] ? NW'(-vec_i[i]) : NW'(vec_i[i]);
        end
        mx1_next = mag1_next[0];
        if (mag1_next[1] > mx1_next) mx1_next = mag1_next[1];
        if (mag1_next[2] > mx1_next) mx1_next = mag1_next[2];
    end

    // Stage 2: leading one of the largest magnitude
    logic [2:0][NW-1:0] mag2_reg;
    logic [2:0]         neg2_reg;
    logic               zero2_reg, zero2_next;
    logic [LW-1:0]      lead2_reg, lead2_next;

    always_comb begin
        zero2_next = (mx1_reg == '0);
        lead2_next = '0;
        for (int b = 0; b < NW; b++) begin
            if (mx1_reg[b]) lead2_next = LW'(b);
        end
    end

    // Stage 3: bring the largest magnitude into [2^19, 2^20)
    logic [NW-1:0]      ms_full [3];
    logic [2:0][MW-1:0] ms3_reg, ms3_next;
    logic [2:0]         neg3_reg;
    logic               zero3_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (lead2_reg >= TOP) ms_full[i] = mag2_reg[i] >> (lead2_reg - TOP);
            else                  ms_full[i] = mag2_reg[i] << (TOP - lead2_reg);
            ms3_next[i] = ms_full[i][MW-1:0];
        end
    end

    // Stage 4: squares
    logic [2*MW-1:0]    sq4_reg [3];
    logic [2:0][MW-1:0] ms4_reg;
    logic [2:0]         neg4_reg;
    logic               zero4_reg;

    // Stage 5: sum of squares
    logic [L2W-1:0]     len2_reg;
    logic [2:0][MW-1:0] ms5_reg;
    logic [2:0]         neg5_reg;
    logic               zero5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            mx1_reg   <= mx1_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero2_next;
            lead2_reg <= lead2_next;
            ms3_reg   <= ms3_next;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= ms3_reg[i] * ms3_reg[i];
            end
            ms4_reg   <= ms3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            len2_reg  <= L2W'(sq4_reg[0]) + L2W'(sq4_reg[1]) + L2W'(sq4_reg[2]);
            ms5_reg   <= ms4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // Square root: one result bit per stage, remainder form
    logic [L2W-1:0]     sq_rem_reg  [RW];
    logic [RW-1:0]      sq_root_reg [RW];
    logic [2:0][MW-1:0] sq_ms_reg   [RW];
    logic [2:0]         sq_neg_reg  [RW];
    logic               sq_zero_reg [RW];
    logic [L2W-1:0]     sq_rem_in   [RW];
    logic [RW-1:0]      sq_root_in  [RW];
    logic [TW-1:0]      sq_trial    [RW];
    logic [L2W-1:0]     sq_rem_next [RW];
    logic [RW-1:0]      sq_root_next[RW];

    always_comb begin
        sq_rem_in[0]  = len2_reg;
        sq_root_in[0] = '0;
        for (int k = 1; k < RW; k++) begin
            sq_rem_in[k]  = sq_rem_reg[k-1];
            sq_root_in[k] = sq_root_reg[k-1];
        end
        for (int k = 0; k < RW; k++) begin
            sq_trial[k] = (TW'(sq_root_in[k]) << (RW - k)) + (TW'(1) << (2 * (RW - 1 - k)));
            if (TW'(sq_rem_in[k]) >= sq_trial[k]) begin
                sq_rem_next[k]  = sq_rem_in[k] - sq_trial[k][L2W-1:0];
                sq_root_next[k] = sq_root_in[k] | (RW'(1) << (RW - 1 - k));
            end else begin
                sq_rem_next[k]  = sq_rem_in[k];
                sq_root_next[k] = sq_root_in[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < RW; k++) begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end
            sq_ms_reg[0]   <= ms5_reg;
            sq_neg_reg[0]  <= neg5_reg;
            sq_zero_reg[0] <= zero5_reg;
            for (int k = 1; k < RW; k++) begin
                sq_ms_reg[k]   <= sq_ms_reg[k-1];
                sq_neg_reg[k]  <= sq_neg_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
            end
        end
    end

    // Division: one quotient bit per stage, three lanes share the length
    logic [2:0][DR-1:0] dv_rem_reg  [QB];
    logic [2:0][QB-1:0] dv_q_reg    [QB];
    logic [RW-1:0]      dv_len_reg  [QB];
    logic [2:0]         dv_neg_reg  [QB];
    logic               dv_zero_reg [QB];
    logic [2:0][DR-1:0] dv_rem_in   [QB];
    logic [2:0][QB-1:0] dv_q_in     [QB];
    logic [RW-1:0]      dv_len_in   [QB];
    logic [DW-1:0]      dv_trial    [QB];
    logic [2:0][DR-1:0] dv_rem_next [QB];
    logic [2:0][QB-1:0] dv_q_next   [QB];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_rem_in[0][i] = {sq_ms_reg[RW-1][i], {fph_pkg::CFRAC{1'b0}}};
            dv_q_in[0][i]   = '0;
        end
        dv_len_in[0] = sq_root_reg[RW-1];
        for (int j = 1; j < QB; j++) begin
            dv_rem_in[j] = dv_rem_reg[j-1];
            dv_q_in[j]   = dv_q_reg[j-1];
            dv_len_in[j] = dv_len_reg[j-1];
        end
        for (int j = 0; j < QB; j++) begin
            dv_trial[j] = DW'(dv_len_in[j]) << (QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (DW'(dv_rem_in[j][i]) >= dv_trial[j]) begin
                    dv_rem_next[j][i] = dv_rem_in[j][i] - dv_trial[j][DR-1:0];
                    dv_q_next[j][i]   = dv_q_in[j][i] | (QB'(1) << (QB - 1 - j));
                end else begin
                    dv_rem_next[j][i] = dv_rem_in[j][i];
                    dv_q_next[j][i]   = dv_q_in[j][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < QB; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_len_reg[j] <= dv_len_in[j];
            end
            dv_neg_reg[0]  <= sq_neg_reg[RW-1];
            dv_zero_reg[0] <= sq_zero_reg[RW-1];
            for (int j = 1; j < QB; j++) begin
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
            end
        end
    end

    // Output: restore signs, force the zero vector
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_zero_reg[QB-1])
                    vec_o[i] <= '0;
                else if (dv_neg_reg[QB-1][i])
                    vec_o[i] <= -fph_pkg::nout_t'(dv_q_reg[QB-1][i]);
                else
                    vec_o[i] <= fph_pkg::nout_t'(dv_q_reg[QB-1][i]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fragment_phong_shader.sv
// Top level of the fragment shader: config registers, shading pipeline, output skid.
`default_nettype none

// Shades one fragment per clock: a new word is taken every cycle while the
// output side keeps up. A fragment's result passes two normalizer banks in
// series (normal, light and view vectors, then the reflected vector), each
// 40 stages of scaling, sum of squares, bit-per-stage square root and division.
// The whole pipeline advances together and freezes only when both the output
// register and the skid register behind it hold words. Colors are signed Q3.12,
// saturated; the depth word passes through untouched. The user must write
// configuration only while no fragment is in flight; the block does not check it.
module fragment_phong_shader (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [63:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_normal_x,
    input  wire logic signed [15:0] s_normal_y,
    input  wire logic signed [15:0] s_normal_z,
    input  wire logic signed [31:0] s_world_x,
    input  wire logic signed [31:0] s_world_y,
    input  wire logic signed [31:0] s_world_z,
    input  wire logic signed [15:0] s_texel_r,
    input  wire logic signed [15:0] s_texel_g,
    input  wire logic signed [15:0] s_texel_b,
    input  wire logic signed [15:0] s_texel_a,
    input  wire logic [31:0]        s_depth_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_color_r,
    output logic signed [15:0]      m_color_g,
    output logic signed [15:0]      m_color_b,
    output logic signed [15:0]      m_color_a,
    output logic [31:0]             m_depth_out
);

    localparam int NL   = fph_pkg::NORM_LAT;
    localparam int LAST = 2 * NL + 13;
    localparam int CF   = fph_pkg::CFRAC;

    typedef struct packed {
        logic [3:0][15:0] alb;
        logic [31:0]      depth;
        logic [2:0][15:0] nraw;
    } side1_t;

    typedef struct packed {
        logic [3:0][15:0]                  alb;
        logic [31:0]                       depth;
        logic [2:0][fph_pkg::NOUT_W-1:0]   e;
        logic [17:0]                       ndl;
    } side2_t;

    typedef struct packed {
        logic [3:0][15:0] alb;
        logic [31:0]      depth;
        logic [17:0]      ndl;
    } tail_t;

    typedef struct packed {
        logic [3:0][15:0] color;
        logic [31:0]      depth;
    } res_t;

    // Configuration registers
    logic [1:0]         mode_reg;
    logic               tex_reg;
    logic [63:0]        base_reg;
    logic [47:0]        ldir_reg;
    logic [63:0]        lcol_reg;
    logic signed [31:0] cam_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            tex_reg  <= 1'b0;
            base_reg <= '0;
            ldir_reg <= '0;
            lcol_reg <= '0;
            for (int i = 0; i < 3; i++) cam_reg[i] <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                fph_pkg::REG_MODE: mode_reg   <= cfg_wdata[1:0];
                fph_pkg::REG_TEX:  tex_reg    <= cfg_wdata[0];
                fph_pkg::REG_BASE: base_reg   <= cfg_wdata;
                fph_pkg::REG_LDIR: ldir_reg   <= cfg_wdata[47:0];
                fph_pkg::REG_LCOL: lcol_reg   <= cfg_wdata;
                fph_pkg::REG_CAMX: cam_reg[0] <= cfg_wdata[31:0];
                fph_pkg::REG_CAMY: cam_reg[1] <= cfg_wdata[31:0];
                fph_pkg::REG_CAMZ: cam_reg[2] <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] lc [4];
    always_comb begin
        for (int i = 0; i < 4; i++) lc[i] = lcol_reg[16*i +: 16];
    end

    // Pipeline control: everything advances together
    logic             adv;
    logic [LAST:0]    vld_reg;
    logic             skid_vld_reg;
    logic             m_valid_reg;

    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    // Stage 0: capture the word, pick albedo, form the view vector
    logic [3:0][15:0]  alb0_reg;
    logic [31:0]       depth0_reg;
    logic [2:0][15:0]  nrm0_reg;
    fph_pkg::nin_t     ev0_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            alb0_reg   <= tex_reg ? {s_texel_a, s_texel_b, s_texel_g, s_texel_r} : base_reg;
            depth0_reg <= s_depth_in;
            nrm0_reg   <= {s_normal_z, s_normal_y, s_normal_x};
            ev0_reg[0] <= fph_pkg::nin_t'(cam_reg[0]) - fph_pkg::nin_t'(s_world_x);
            ev0_reg[1] <= fph_pkg::nin_t'(cam_reg[1]) - fph_pkg::nin_t'(s_world_y);
            ev0_reg[2] <= fph_pkg::nin_t'(cam_reg[2]) - fph_pkg::nin_t'(s_world_z);
        end
    end

    // Normalize normal, light direction and view vector in parallel
    fph_pkg::nin_t  na_in [3];
    fph_pkg::nin_t  nb_in [3];
    fph_pkg::nout_t un_w  [3];
    fph_pkg::nout_t ld_w  [3];
    fph_pkg::nout_t e_w   [3];
    fph_pkg::nout_t r_w   [3];
    fph_pkg::nin_t  rr44_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            na_in[i] = fph_pkg::nin_t'($signed(nrm0_reg[i]));
            nb_in[i] = fph_pkg::nin_t'($signed(ldir_reg[16*i +: 16]));
        end
    end

    fph_norm u_norm_n (.aclk(aclk), .en(adv), .vec_i(na_in),    .vec_o(un_w));
    fph_norm u_norm_l (.aclk(aclk), .en(adv), .vec_i(nb_in),    .vec_o(ld_w));
    fph_norm u_norm_e (.aclk(aclk), .en(adv), .vec_i(ev0_reg),  .vec_o(e_w));

    // Carry albedo, depth and raw normal beside the normalizers
    side1_t side1_reg [NL];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg[0] <= '{alb: alb0_reg, depth: depth0_reg, nraw: nrm0_reg};
            for (int k = 1; k < NL; k++) side1_reg[k] <= side1_reg[k-1];
        end
    end

    // Stage 41: dot product terms
    logic signed [29:0] dp41_reg [3];
    logic signed [29:0] n1p41_reg [3];
    logic signed [29:0] n2p41_reg [3];
    fph_pkg::nout_t     un41_reg [3];
    fph_pkg::nout_t     ld41_reg [3];
    side2_t             sd41_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dp41_reg[i]  <= 30'(-ld_w[i]) * 30'(un_w[i]);
                n1p41_reg[i] <= 30'($signed(side1_reg[NL-1].nraw[i])) * 30'(ld_w[i]);
                n2p41_reg[i] <= 30'(un_w[i]) * 30'(ld_w[i]);
                un41_reg[i]  <= un_w[i];
                ld41_reg[i]  <= ld_w[i];
            end
            sd41_reg.alb   <= side1_reg[NL-1].alb;
            sd41_reg.depth <= side1_reg[NL-1].depth;
            sd41_reg.e     <= {e_w[2], e_w[1], e_w[0]};
            sd41_reg.ndl   <= '0;
        end
    end

    // Stage 42: reduce to -(l.n) and the clamped diffuse factor
    logic signed [31:0] dsum42, n1sum42, n2sum42, nsum42;
    logic signed [19:0] d42_reg;
    fph_pkg::nout_t     un42_reg [3];
    fph_pkg::nout_t     ld42_reg [3];
    side2_t             sd42_reg;

    always_comb begin
        dsum42  = 32'(dp41_reg[0]) + 32'(dp41_reg[1]) + 32'(dp41_reg[2]);
        n1sum42 = 32'(n1p41_reg[0]) + 32'(n1p41_reg[1]) + 32'(n1p41_reg[2]);
        n2sum42 = 32'(n2p41_reg[0]) + 32'(n2p41_reg[1]) + 32'(n2p41_reg[2]);
        nsum42  = (mode_reg == fph_pkg::MODE_DIFFUSE) ? n1sum42 : n2sum42;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d42_reg  <= 20'(dsum42 >>> CF);
            un42_reg <= un41_reg;
            ld42_reg <= ld41_reg;
            sd42_reg.alb   <= sd41_reg.alb;
            sd42_reg.depth <= sd41_reg.depth;
            sd42_reg.e     <= sd41_reg.e;
            sd42_reg.ndl   <= (nsum42 < 0) ? 18'd0 : 18'(nsum42 >>> CF);
        end
    end

    // Stage 43: -2(l.n) times the unit normal
    logic signed [35:0] rp43_reg [3];
    fph_pkg::nout_t     ld43_reg [3];
    side2_t             sd43_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                rp43_reg[i] <= (36'(d42_reg) * 36'(un42_reg[i])) <<< 1;
                ld43_reg[i] <= ld42_reg[i];
            end
            sd43_reg <= sd42_reg;
        end
    end

    // Stage 44: reflected vector, still unnormalized
    side2_t sd44_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                rr44_reg[i] <= fph_pkg::nin_t'(rp43_reg[i] >>> CF) +
                               fph_pkg::nin_t'(ld43_reg[i]);
            end
            sd44_reg <= sd43_reg;
        end
    end

    fph_norm u_norm_r (.aclk(aclk), .en(adv), .vec_i(rr44_reg), .vec_o(r_w));

    side2_t side2_reg [NL];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side2_reg[0] <= sd44_reg;
            for (int k = 1; k < NL; k++) side2_reg[k] <= side2_reg[k-1];
        end
    end

    // Stage 85: r.e terms
    logic signed [29:0] re85_reg [3];
    tail_t              tl85_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                re85_reg[i] <= 30'(r_w[i]) * 30'($signed(side2_reg[NL-1].e[i]));
            end
            tl85_reg <= '{alb: side2_reg[NL-1].alb, depth: side2_reg[NL-1].depth,
                          ndl: side2_reg[NL-1].ndl};
        end
    end

    // Stage 86: clamp r.e into [0, one]
    logic signed [31:0] resum86;
    logic signed [19:0] rsh86;
    logic [CF:0]        s86_reg;
    tail_t              tl86_reg;

    always_comb begin
        resum86 = 32'(re85_reg[0]) + 32'(re85_reg[1]) + 32'(re85_reg[2]);
        rsh86   = 20'(resum86 >>> CF);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (rsh86 < 0)                         s86_reg <= '0;
            else if (rsh86 > 20'(fph_pkg::ONE_VAL)) s86_reg <= (CF+1)'(fph_pkg::ONE_VAL);
            else                                   s86_reg <= rsh86[CF:0];
            tl86_reg <= tl85_reg;
        end
    end

    // Stages 87-90: raise to the sixteenth power, one squaring per stage
    logic [CF:0] pow_reg [4];
    tail_t       pw_tl_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            pow_reg[0]   <= (CF+1)'((2*(CF+1))'(s86_reg) * (2*(CF+1))'(s86_reg) >> CF);
            pw_tl_reg[0] <= tl86_reg;
            for (int k = 1; k < 4; k++) begin
                pow_reg[k]   <= (CF+1)'((2*(CF+1))'(pow_reg[k-1]) *
                                        (2*(CF+1))'(pow_reg[k-1]) >> CF);
                pw_tl_reg[k] <= pw_tl_reg[k-1];
            end
        end
    end

    // Stage 91: ambient, specular and first diffuse product
    logic signed [21:0] p191_reg [4];
    logic signed [15:0] amb91_reg [4];
    logic signed [16:0] spec91_reg [4];
    logic [3:0][15:0]   alb91_reg;
    logic [31:0]        depth91_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                p191_reg[i]   <= 22'((34'(lc[i]) *
                                      34'($signed(pw_tl_reg[3].ndl))) >>> CF);
                amb91_reg[i]  <= 16'((28'($signed(pw_tl_reg[3].alb[i])) *
                                      28'(fph_pkg::AMB_K)) >>> CF);
                spec91_reg[i] <= 17'((30'(lc[i]) *
                                      30'($signed({1'b0, pow_reg[3]}))) >>> CF);
            end
            alb91_reg   <= pw_tl_reg[3].alb;
            depth91_reg <= pw_tl_reg[3].depth;
        end
    end

    // Stage 92: diffuse term times albedo
    logic signed [25:0] dif92_reg [4];
    logic signed [15:0] amb92_reg [4];
    logic signed [16:0] spec92_reg [4];
    logic [3:0][15:0]   alb92_reg;
    logic [31:0]        depth92_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                dif92_reg[i]  <= 26'((38'(p191_reg[i]) *
                                      38'($signed(alb91_reg[i]))) >>> CF);
                amb92_reg[i]  <= amb91_reg[i];
                spec92_reg[i] <= spec91_reg[i];
            end
            alb92_reg   <= alb91_reg;
            depth92_reg <= depth91_reg;
        end
    end

    // Stage 93: combine by mode and saturate
    logic signed [27:0] sum93 [4];
    logic signed [27:0] pick93 [4];
    res_t               res93_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i == 3)
                sum93[i] = 28'(amb92_reg[i]) + 28'(fph_pkg::ONE_VAL) + 28'(dif92_reg[i]);
            else
                sum93[i] = 28'(amb92_reg[i]) + 28'(spec92_reg[i]) + 28'(dif92_reg[i]);
            case (mode_reg)
                fph_pkg::MODE_PHONG:   pick93[i] = sum93[i];
                fph_pkg::MODE_DIFFUSE: pick93[i] = 28'(dif92_reg[i]);
                default:               pick93[i] = 28'($signed(alb92_reg[i]));
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                if (pick93[i] > 28'sd32767)       res93_reg.color[i] <= 16'h7FFF;
                else if (pick93[i] < -28'sd32768) res93_reg.color[i] <= 16'h8000;
                else                              res93_reg.color[i] <= pick93[i][15:0];
            end
            res93_reg.depth <= depth92_reg;
        end
    end

    // Output register with skid: take one more word while the output waits
    logic push;
    res_t out_reg, skid_reg;

    assign push = adv && vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (push) begin
            if (m_valid_reg && !m_ready) skid_vld_reg <= 1'b1;
            else                         m_valid_reg  <= 1'b1;
        end else if (m_ready) begin
            if (skid_vld_reg) skid_vld_reg <= 1'b0;
            else              m_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            if (m_valid_reg && !m_ready) skid_reg <= res93_reg;
            else                         out_reg  <= res93_reg;
        end else if (m_ready && skid_vld_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_color_r   = out_reg.color[0];
    assign m_color_g   = out_reg.color[1];
    assign m_color_b   = out_reg.color[2];
    assign m_color_a   = out_reg.color[3];
    assign m_depth_out = out_reg.depth;

    // Skid holds a word only behind a valid output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid word without output word");

    // A frozen pipeline keeps its valid bits
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // A word leaving the last stage always lands at the output
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid_reg)
        else $error("result word lost at output");

endmodule

`default_nettype wire
